// ===== rtl/mblit_pkg.sv =====
package mblit_pkg;

  // Configuration register indexes
  localparam logic [2:0] REG_SRC_WIDTH   = 3'd0;
  localparam logic [2:0] REG_DEST_X      = 3'd1;
  localparam logic [2:0] REG_DEST_Y      = 3'd2;
  localparam logic [2:0] REG_DRAW_WIDTH  = 3'd3;
  localparam logic [2:0] REG_DRAW_HEIGHT = 3'd4;
  localparam logic [2:0] REG_DEST_WIDTH  = 3'd5;
  localparam logic [2:0] REG_DEST_HEIGHT = 3'd6;
  localparam logic [2:0] REG_ALPHA_MODE  = 3'd7;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 12;
  localparam int RGB_W       = 24;
  localparam int PADDR_W     = 24;
  localparam int MADDR_W     = 19;
  localparam int COORD_W     = 12;  // destination coordinates stay below 4096
  localparam int RGB_STRIDE_W = 14;
  localparam int MSK_STRIDE_W = 10;

  localparam logic [2:0] BIT_IN_BYTE = 3'h7;
  localparam logic [7:0] MSB_BIT     = 8'h80;

  typedef struct packed {
    logic [11:0] src_width;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [11:0] draw_width;
    logic [11:0] draw_height;
    logic [11:0] dest_width;
    logic [11:0] dest_height;
    logic        alpha_mode;
  } cfg_t;

  // Classified request passed from front to back
  typedef struct packed {
    logic               pixel_write;
    logic               mask_write;
    logic [COORD_W-1:0] dx;
    logic [COORD_W-1:0] dy;
    logic [RGB_W-1:0]   rgb;
  } entry_t;

endpackage

// ===== rtl/mblit_if.sv =====
interface mblit_in_if;
  logic        valid;
  logic        ready;
  logic [23:0] pixel_rgb;
  logic        mask_bit;
  logic        frame_last;

  modport source (output valid, pixel_rgb, mask_bit, frame_last, input ready);
  modport sink   (input valid, pixel_rgb, mask_bit, frame_last, output ready);
endinterface

interface mblit_out_if;
  logic        valid;
  logic        ready;
  logic        pixel_write;
  logic [23:0] pixel_address;
  logic [23:0] pixel_data;
  logic        mask_write;
  logic [18:0] mask_address;
  logic [7:0]  mask_set_bits;

  modport source (output valid, pixel_write, pixel_address, pixel_data, mask_write,
                  mask_address, mask_set_bits, input ready);
  modport sink   (input valid, pixel_write, pixel_address, pixel_data, mask_write,
                  mask_address, mask_set_bits, output ready);
endinterface

interface mblit_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/mblit_front.sv =====
module mblit_front #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic              clk,
  input  logic              rst,
  mblit_in_if.sink          pixels,
  input  mblit_pkg::cfg_t   cfg,
  input  logic              queue_full,
  output logic              push,
  output mblit_pkg::entry_t push_entry
);

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int RW     = $clog2(MAX_HEIGHT);
  localparam int CMP_W  = (CW + 1 > 13) ? CW + 1 : 13;
  localparam int RCMP_W = (RW + 1 > 13) ? RW + 1 : 13;

  logic [CW-1:0]     column_count, column_count_next;
  logic [RW-1:0]     row_count, row_count_next;
  logic              in_range;
  logic [11:0]       span_w, span_h, vw, vh, src_len;
  logic [CMP_W-1:0]  col_x, row_len;
  logic [RCMP_W-1:0] row_x;
  logic              in_clip, pw;

  assign pixels.ready = !queue_full;
  assign push         = pixels.valid && pixels.ready;

  // clip window
  assign in_range = (12'(cfg.dest_x) < cfg.dest_width) && (12'(cfg.dest_y) < cfg.dest_height);
  assign span_w   = cfg.dest_width - 12'(cfg.dest_x);
  assign span_h   = cfg.dest_height - 12'(cfg.dest_y);

  always_comb begin
    vw = (cfg.draw_width < span_w) ? cfg.draw_width : span_w;
    if (cfg.src_width < vw) begin
      vw = cfg.src_width;
    end
    vh = (cfg.draw_height < span_h) ? cfg.draw_height : span_h;
  end

  assign col_x   = CMP_W'(column_count);
  assign row_x   = RCMP_W'(row_count);
  assign in_clip = in_range && (col_x < CMP_W'(vw)) && (row_x < RCMP_W'(vh));
  assign pw      = in_clip && (!cfg.alpha_mode || pixels.mask_bit);

  always_comb begin
    push_entry.pixel_write = pw;
    push_entry.mask_write  = pw && cfg.alpha_mode;
    push_entry.dx  = mblit_pkg::COORD_W'(CMP_W'(cfg.dest_x) + col_x);
    push_entry.dy  = mblit_pkg::COORD_W'(RCMP_W'(cfg.dest_y) + row_x);
    push_entry.rgb = pixels.pixel_rgb;
  end

  // raster position; a zero source width counts as one
  assign src_len = (cfg.src_width == 12'd0) ? 12'd1 : cfg.src_width;
  assign row_len = (CMP_W'(src_len) > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : CMP_W'(src_len);

  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    if (pixels.frame_last) begin
      column_count_next = '0;
      row_count_next    = '0;
    end else if (col_x + CMP_W'(1) >= row_len) begin
      column_count_next = '0;
      row_count_next    = (row_x + RCMP_W'(1) >= RCMP_W'(MAX_HEIGHT)) ? '0
                          : RW'(row_x + RCMP_W'(1));
    end else begin
      column_count_next = CW'(col_x + CMP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (push) begin
      column_count <= column_count_next;
      row_count    <= row_count_next;
    end
  end

endmodule

// ===== rtl/mblit_queue.sv =====
module mblit_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  mblit_pkg::entry_t push_entry,
  output logic              full,
  input  logic              pop,
  output logic              not_empty,
  output mblit_pkg::entry_t pop_entry
);

  mblit_pkg::entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'd2);
  assign not_empty = (count != 2'd0);
  assign pop_entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/mblit_back.sv =====
module mblit_back (
  input  logic              clk,
  input  logic              rst,
  input  mblit_pkg::cfg_t   cfg,
  input  logic              avail,
  input  mblit_pkg::entry_t entry,
  output logic              pop,
  mblit_out_if.source       results
);

  logic [mblit_pkg::RGB_STRIDE_W-1:0] rgb_stride;
  logic [mblit_pkg::MSK_STRIDE_W-1:0] msk_stride;
  logic [25:0] row_base;
  logic [21:0] mrow_base;
  logic [13:0] dx3;
  logic        out_valid;

  // strides are registered, following the configuration in the next cycle
  always_ff @(posedge clk) begin
    rgb_stride <= mblit_pkg::RGB_STRIDE_W'((14'(cfg.dest_width) * 14'd3 + 14'd3) & ~14'h3);
    msk_stride <= mblit_pkg::MSK_STRIDE_W'((((13'(cfg.dest_width) + 13'd7) >> 3) + 13'd3)
                  & ~13'h3);
  end

  assign pop       = avail && (!out_valid || results.ready);
  assign row_base  = 26'(entry.dy) * 26'(rgb_stride);
  assign mrow_base = 22'(entry.dy) * 22'(msk_stride);
  assign dx3       = {1'b0, entry.dx, 1'b0} + 14'(entry.dx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      results.pixel_write   <= entry.pixel_write;
      results.pixel_address <= entry.pixel_write
                               ? mblit_pkg::PADDR_W'(row_base + 26'(dx3)) : '0;
      results.pixel_data    <= entry.pixel_write ? entry.rgb : '0;
      results.mask_write    <= entry.mask_write;
      results.mask_address  <= entry.mask_write
                               ? mblit_pkg::MADDR_W'(mrow_base + 22'(entry.dx >> 3)) : '0;
      results.mask_set_bits <= entry.mask_write
                               ? (mblit_pkg::MSB_BIT >> (entry.dx[2:0] & mblit_pkg::BIT_IN_BYTE))
                               : '0;
    end
  end

  assign results.valid = out_valid;

endmodule

// ===== rtl/masked_blit_one_bit_alpha_unit.sv =====
// Channel   Role  Handshake    Payload
// pixels    sink  valid/ready  pixel_rgb, mask_bit, frame_last
// results   src   valid/ready  pixel_write/address/data, mask_write/address/set_bits
// cfg       sink  valid/ready  index (3b), data (12b); ready always high
//
// One request accepted per clock while the queue is not full; each result passes
// through a queue slot, then the address multiply into the output register.
// Throughput is set by the two-entry queue and the output register: full rate
// while results are taken, pixels.ready drops only once the queue fills.
// rst is synchronous: clears counters, queue occupancy, output valid and the
// registers to their defaults. Strides are re-registered from the config registers.
module masked_blit_one_bit_alpha_unit #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic        clk,
  input  logic        rst,
  mblit_in_if.sink    pixels,
  mblit_out_if.source results,
  mblit_cfg_if.sink   cfg
);

  mblit_pkg::cfg_t   regs;
  mblit_pkg::entry_t push_entry, pop_entry;
  logic              push, pop, queue_full, queue_avail;

  assign cfg.ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (rst) begin
      regs.src_width   <= 12'd1;
      regs.dest_x      <= 11'd0;
      regs.dest_y      <= 11'd0;
      regs.draw_width  <= 12'd0;
      regs.draw_height <= 12'd0;
      regs.dest_width  <= 12'd1;
      regs.dest_height <= 12'd1;
      regs.alpha_mode  <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        mblit_pkg::REG_SRC_WIDTH:   regs.src_width   <= cfg.data;
        mblit_pkg::REG_DEST_X:      regs.dest_x      <= cfg.data[10:0];
        mblit_pkg::REG_DEST_Y:      regs.dest_y      <= cfg.data[10:0];
        mblit_pkg::REG_DRAW_WIDTH:  regs.draw_width  <= cfg.data;
        mblit_pkg::REG_DRAW_HEIGHT: regs.draw_height <= cfg.data;
        mblit_pkg::REG_DEST_WIDTH:  regs.dest_width  <= cfg.data;
        mblit_pkg::REG_DEST_HEIGHT: regs.dest_height <= cfg.data;
        mblit_pkg::REG_ALPHA_MODE:  regs.alpha_mode  <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // front: raster counters and clip test
  mblit_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .pixels     (pixels),
    .cfg        (regs),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // decouples the front from output stalls
  mblit_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .not_empty  (queue_avail),
    .pop_entry  (pop_entry)
  );

  // back: address arithmetic and output register
  mblit_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (regs),
    .avail   (queue_avail),
    .entry   (pop_entry),
    .pop     (pop),
    .results (results)
  );

endmodule

// ===== rtl/mblit_check.sv =====
module mblit_check (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic        pixel_write,
  input logic [23:0] pixel_address,
  input logic [23:0] pixel_data,
  input logic        mask_write,
  input logic [7:0]  mask_set_bits
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_mask_needs_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && mask_write |-> pixel_write && $onehot(mask_set_bits))
    else $error("mask write without pixel write or bad bit");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !pixel_write |-> pixel_address == 24'd0 && pixel_data == 24'd0
      && !mask_write && mask_set_bits == 8'd0)
    else $error("non-zero fields without write");

endmodule

bind masked_blit_one_bit_alpha_unit mblit_check u_check (
  .clk           (clk),
  .rst           (rst),
  .out_valid     (results.valid),
  .out_ready     (results.ready),
  .pixel_write   (results.pixel_write),
  .pixel_address (results.pixel_address),
  .pixel_data    (results.pixel_data),
  .mask_write    (results.mask_write),
  .mask_set_bits (results.mask_set_bits)
);
